[rtl/core/paged_block_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Paged block allocator assertion macros
// Concurrent check helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PAGED_BLOCK_ALLOCATOR_MACROS_SVH
`define PAGED_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pba assertion failed");

// next-cycle implication
`define PBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pba assertion failed");

`else

`define PBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/pba_pkg.sv]
// ----------------------------------------------------------------------------
// Paged block allocator package
// Operation, status and block state codes, FSM states and control bundles.
// ----------------------------------------------------------------------------
package pba_pkg;

    // payload field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned SEQ_W    = 6;
    localparam int unsigned LIDX_W   = 6;
    localparam int unsigned BST_W    = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned PHYS_W   = 10;
    localparam int unsigned LPOS_W   = 6;

    // max words a query returns
    localparam int unsigned RESULT_CAP = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_RANGE     = 3'd3,
        ST_BAD_STATE = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [BST_W-1:0] {
        BS_HOT     = 2'd0,
        BS_WARM    = 2'd1,
        BS_COLD    = 2'd2,
        BS_INVALID = 2'd3
    } t_blk_state;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ERR,
        S_POP,
        S_UPDATE,
        S_FREE,
        S_FREE_DONE,
        S_QUERY
    } t_state;

    // free stack commands
    typedef struct packed {
        logic rd_top;
        logic pop;
        logic push;
    } t_stack_ctl;

    // count and block table commands
    typedef struct packed {
        logic cnt_rd;
        logic cnt_wr;
        logic tbl_rd;
        logic tbl_wr;
    } t_tbl_ctl;

endpackage

[rtl/core/pba_ifs.sv]
// ----------------------------------------------------------------------------
// Paged block allocator channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface pba_req_if;
    import pba_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SEQ_W-1:0]  seq_id;
    logic [LIDX_W-1:0] logical_index;
    logic [BST_W-1:0]  target_state;

    modport source (output valid, operation, seq_id, logical_index, target_state,
                    input ready);
    modport sink   (input valid, operation, seq_id, logical_index, target_state,
                    output ready);
endinterface

interface pba_rsp_if;
    import pba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PHYS_W-1:0]   physical_index;
    logic [LPOS_W-1:0]   logical_position;
    logic [BST_W-1:0]    block_state;
    logic                last;

    modport source (output valid, status, physical_index, logical_position,
                    block_state, last, input ready);
    modport sink   (input valid, status, physical_index, logical_position,
                    block_state, last, output ready);
endinterface

[rtl/core/pba_free_stack.sv]
// ----------------------------------------------------------------------------
// Paged block allocator free stack
// LIFO of free physical block indexes in one synchronous RAM. Entries never
// written since reset read as their reset value via a low-water mark.
// ----------------------------------------------------------------------------
`include "paged_block_allocator_macros.svh"

module pba_free_stack #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pba_pkg::t_stack_ctl           i_ctl,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_push_data,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_top_data,
    output logic                          o_empty
);
    import pba_pkg::*;

    localparam int PW   = $clog2(NUM_BLOCKS);
    localparam int CNTW = $clog2(NUM_BLOCKS + 1);
    localparam logic [PW-1:0]   TOP_IDX  = PW'(NUM_BLOCKS - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(NUM_BLOCKS);

    logic [PW-1:0]   r_mem [NUM_BLOCKS];
    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] r_low;      // lowest fill seen; entries at or above it are written
    logic [PW-1:0]   r_rd_data;
    logic [PW-1:0]   r_rd_addr;
    logic            r_rd_written;
    logic [PW-1:0]   top_addr;
    logic            push_ok;

    assign top_addr = PW'(r_count - 1'b1);
    assign push_ok  = i_ctl.push && (r_count != FULL_CNT);  // push onto full stack dropped
    assign o_empty  = (r_count == '0);

    // RAM write port
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[PW'(r_count)] <= i_push_data;
        end
    end

    // RAM read port, top of stack
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_top) begin
            r_rd_data    <= r_mem[top_addr];
            r_rd_addr    <= top_addr;
            r_rd_written <= (r_low < r_count);
        end
    end

    // untouched entries hold NUM_BLOCKS-1-k
    assign o_top_data = r_rd_written ? r_rd_data : (TOP_IDX - r_rd_addr);

    // fill count and low-water mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= FULL_CNT;
            r_low   <= FULL_CNT;
        end else if (i_ctl.pop) begin
            r_count <= r_count - 1'b1;
            if (r_low == r_count) begin
                r_low <= r_count - 1'b1;
            end
        end else if (push_ok) begin
            r_count <= r_count + 1'b1;
        end
    end

    `PBA_ASSERT_IMPL(a_low_below_count, i_clk, i_rst_n, 1'b1, r_low <= r_count)
    `PBA_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_ctl.pop, r_count != '0)

endmodule

[rtl/core/pba_seq_table.sv]
// ----------------------------------------------------------------------------
// Paged block allocator sequence tables
// Per-sequence block count RAM (cleared by a sweep after reset) and the
// block table RAM holding physical index and state of each block.
// ----------------------------------------------------------------------------
`include "paged_block_allocator_macros.svh"

module pba_seq_table #(
    parameter int NUM_BLOCKS         = 1024,
    parameter int MAX_SEQS           = 64,
    parameter int MAX_BLOCKS_PER_SEQ = 64
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  pba_pkg::t_tbl_ctl                              i_ctl,
    input  logic [((MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1)-1:0] i_seq,
    input  logic [$clog2(MAX_BLOCKS_PER_SEQ + 1)-1:0]      i_cnt_wdata,
    output logic [$clog2(MAX_BLOCKS_PER_SEQ + 1)-1:0]      o_cnt,
    input  logic [((MAX_BLOCKS_PER_SEQ > 1) ? $clog2(MAX_BLOCKS_PER_SEQ) : 1)-1:0] i_blk,
    input  logic [$clog2(NUM_BLOCKS)-1:0]                  i_tbl_wphys,
    input  logic [pba_pkg::BST_W-1:0]                      i_tbl_wstate,
    output logic [$clog2(NUM_BLOCKS)-1:0]                  o_tbl_phys,
    output logic [pba_pkg::BST_W-1:0]                      o_tbl_state,
    output logic                                           o_busy
);
    import pba_pkg::*;

    localparam int SIW = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
    localparam int CW  = $clog2(MAX_BLOCKS_PER_SEQ + 1);
    localparam int PW  = $clog2(NUM_BLOCKS);
    localparam int TE  = MAX_SEQS * MAX_BLOCKS_PER_SEQ;
    localparam int TAW = (TE > 1) ? $clog2(TE) : 1;
    localparam int TWW = PW + BST_W;

    logic [CW-1:0]  r_cnt_mem [MAX_SEQS];
    logic [TWW-1:0] r_tbl_mem [TE];
    logic [CW-1:0]  r_cnt_rd;
    logic [TWW-1:0] r_tbl_rd;
    logic [SIW-1:0] r_clr_idx;
    logic           r_busy;
    logic [TAW-1:0] tbl_addr;

    assign tbl_addr = TAW'(TAW'(i_seq) * TAW'(MAX_BLOCKS_PER_SEQ) + TAW'(i_blk));

    // clearing sweep over the count RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            if (r_clr_idx == SIW'(MAX_SEQS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign o_busy = r_busy;

    // count RAM
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_cnt_mem[r_clr_idx] <= '0;
        end else if (i_ctl.cnt_wr) begin
            r_cnt_mem[i_seq] <= i_cnt_wdata;
        end
        if (i_ctl.cnt_rd) begin
            r_cnt_rd <= r_cnt_mem[i_seq];
        end
    end

    assign o_cnt = r_cnt_rd;

    // block table RAM
    always_ff @(posedge i_clk) begin
        if (i_ctl.tbl_wr) begin
            r_tbl_mem[tbl_addr] <= {i_tbl_wphys, i_tbl_wstate};
        end
        if (i_ctl.tbl_rd) begin
            r_tbl_rd <= r_tbl_mem[tbl_addr];
        end
    end

    assign o_tbl_phys  = r_tbl_rd[TWW-1:BST_W];
    assign o_tbl_state = r_tbl_rd[BST_W-1:0];

    `PBA_ASSERT_IMPL(a_no_access_in_clear, i_clk, i_rst_n, r_busy, !i_ctl.cnt_rd && !i_ctl.cnt_wr)

endmodule

[rtl/core/paged_block_allocator.sv]
// ----------------------------------------------------------------------------
// Paged block allocator
// Physical block pool kept as a LIFO free stack plus per-sequence block
// tables. Allocate, free, state update and query of a sequence's blocks.
//
//   channel  dir  payload                                              words
//   i_req    in   operation, seq_id, logical_index, target_state       1
//   o_rsp    out  status, physical_index, logical_position,            1..64
//                 block_state, last
//
// Allocate and update go through the count RAM read followed by the stack or
// table RAM read. Query and free read a sequence's table one entry per cycle,
// query only while o_rsp is not stalled. After reset a sweep clears the count
// RAM before i_req is taken. One response word is buffered; a stalled o_rsp
// holds the sequencer at its next word while the buffer stays full.
// ----------------------------------------------------------------------------
`include "paged_block_allocator_macros.svh"

module paged_block_allocator #(
    parameter int NUM_BLOCKS         = 1024,
    parameter int MAX_SEQS           = 64,
    parameter int MAX_BLOCKS_PER_SEQ = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pba_req_if.sink           i_req,
    pba_rsp_if.source         o_rsp
);
    import pba_pkg::*;

    localparam int PW   = $clog2(NUM_BLOCKS);
    localparam int SIW  = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
    localparam int CW   = $clog2(MAX_BLOCKS_PER_SEQ + 1);
    localparam int BIW  = (MAX_BLOCKS_PER_SEQ > 1) ? $clog2(MAX_BLOCKS_PER_SEQ) : 1;
    localparam int QCAP = (MAX_BLOCKS_PER_SEQ < RESULT_CAP) ? MAX_BLOCKS_PER_SEQ
                                                            : RESULT_CAP;

    t_state             r_state, n_state;
    t_op                r_op;
    logic [SEQ_W-1:0]   r_seq;
    logic [LIDX_W-1:0]  r_li;
    logic [BST_W-1:0]   r_ns;
    logic [CW-1:0]      r_idx, n_idx;
    t_status            r_err, n_err;

    // response buffer
    logic               r_out_valid;
    t_status            r_out_status;
    logic [PHYS_W-1:0]  r_out_phys;
    logic [LPOS_W-1:0]  r_out_lpos;
    logic [BST_W-1:0]   r_out_bst;
    logic               r_out_last;

    // sequencer outputs
    t_stack_ctl         stk_ctl;
    t_tbl_ctl           tbl_ctl;
    logic [SIW-1:0]     seq_sel;
    logic [BIW-1:0]     blk_sel;
    logic [CW-1:0]      cnt_wdata;
    logic [PW-1:0]      tbl_wphys;
    logic [BST_W-1:0]   tbl_wstate;
    logic               req_ready;
    logic               emit;
    t_status            e_status;
    logic [PHYS_W-1:0]  e_phys;
    logic [LPOS_W-1:0]  e_lpos;
    logic [BST_W-1:0]   e_bst;
    logic               e_last;

    // datapath
    logic [PW-1:0]      top_data;
    logic               stk_empty;
    logic [CW-1:0]      cnt;
    logic [PW-1:0]      tbl_phys;
    logic [BST_W-1:0]   tbl_state;
    logic               clr_busy;
    logic               out_free;
    logic               seq_ok;
    logic               li_ok;
    logic               seq_full;
    logic [CW-1:0]      query_n;
    logic               accept;

    pba_free_stack #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stk_ctl),
        .i_push_data (tbl_phys),
        .o_top_data  (top_data),
        .o_empty     (stk_empty)
    );

    pba_seq_table #(
        .NUM_BLOCKS         (NUM_BLOCKS),
        .MAX_SEQS           (MAX_SEQS),
        .MAX_BLOCKS_PER_SEQ (MAX_BLOCKS_PER_SEQ)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (tbl_ctl),
        .i_seq        (seq_sel),
        .i_cnt_wdata  (cnt_wdata),
        .o_cnt        (cnt),
        .i_blk        (blk_sel),
        .i_tbl_wphys  (tbl_wphys),
        .i_tbl_wstate (tbl_wstate),
        .o_tbl_phys   (tbl_phys),
        .o_tbl_state  (tbl_state),
        .o_busy       (clr_busy)
    );

    assign accept   = i_req.valid && req_ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign seq_ok   = (32'(r_seq) < MAX_SEQS);
    assign li_ok    = (32'(r_li) < 32'(cnt));
    assign seq_full = (32'(cnt) >= MAX_BLOCKS_PER_SEQ);
    assign query_n  = (32'(cnt) > QCAP) ? CW'(QCAP) : cnt;
    assign seq_sel  = (r_state == S_IDLE) ? SIW'(i_req.seq_id) : SIW'(r_seq);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_err <= n_err;
        if (accept) begin
            r_op  <= t_op'(i_req.operation);
            r_seq <= i_req.seq_id;
            r_li  <= i_req.logical_index;
            r_ns  <= i_req.target_state;
        end
    end

    // sequencer: next state and RAM commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_err      = r_err;
        stk_ctl    = '0;
        tbl_ctl    = '0;
        blk_sel    = '0;
        cnt_wdata  = '0;
        tbl_wphys  = tbl_phys;
        tbl_wstate = BS_HOT;
        req_ready  = 1'b0;
        emit       = 1'b0;
        e_status   = ST_OK;
        e_phys     = '0;
        e_lpos     = '0;
        e_bst      = '0;
        e_last     = 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                if (!clr_busy) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid) begin
                    tbl_ctl.cnt_rd = 1'b1;
                    n_state        = S_DECODE;
                end
            end

            // count is back: run the checks, start the RAM access
            S_DECODE: begin
                if (!seq_ok) begin
                    n_err   = ST_NOT_FOUND;
                    n_state = S_ERR;
                end else begin
                    unique case (r_op)
                        OP_ALLOC: begin
                            if (stk_empty) begin
                                n_err   = ST_NO_FREE;
                                n_state = S_ERR;
                            end else if (seq_full) begin
                                n_err   = ST_FULL;
                                n_state = S_ERR;
                            end else begin
                                stk_ctl.rd_top = 1'b1;
                                n_state        = S_POP;
                            end
                        end
                        OP_FREE, OP_QUERY: begin
                            if (cnt == '0) begin
                                n_err   = ST_NOT_FOUND;
                                n_state = S_ERR;
                            end else begin
                                tbl_ctl.tbl_rd = 1'b1;
                                n_idx          = CW'(1);
                                n_state        = (r_op == OP_FREE) ? S_FREE : S_QUERY;
                            end
                        end
                        OP_UPDATE: begin
                            blk_sel = BIW'(r_li);
                            if (cnt == '0) begin
                                n_err   = ST_NOT_FOUND;
                                n_state = S_ERR;
                            end else if (!li_ok) begin
                                n_err   = ST_RANGE;
                                n_state = S_ERR;
                            end else if (r_ns == BS_INVALID) begin
                                n_err   = ST_BAD_STATE;
                                n_state = S_ERR;
                            end else begin
                                tbl_ctl.tbl_rd = 1'b1;
                                n_state        = S_UPDATE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_ERR: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = r_err;
                    n_state  = S_IDLE;
                end
            end

            // top of stack is back: commit the pop and append as hot
            S_POP: begin
                blk_sel   = BIW'(cnt);
                tbl_wphys = top_data;
                if (out_free) begin
                    emit           = 1'b1;
                    e_phys         = PHYS_W'(top_data);
                    e_lpos         = LPOS_W'(cnt);
                    e_bst          = BS_HOT;
                    stk_ctl.pop    = 1'b1;
                    tbl_ctl.tbl_wr = 1'b1;
                    tbl_ctl.cnt_wr = 1'b1;
                    cnt_wdata      = CW'(cnt + 1'b1);
                    n_state        = S_IDLE;
                end
            end

            // entry is back: write the new state over it
            S_UPDATE: begin
                blk_sel    = BIW'(r_li);
                tbl_wstate = r_ns;
                if (out_free) begin
                    emit           = 1'b1;
                    e_phys         = PHYS_W'(tbl_phys);
                    e_lpos         = r_li;
                    e_bst          = r_ns;
                    tbl_ctl.tbl_wr = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            // push entry idx-1 while reading entry idx
            S_FREE: begin
                stk_ctl.push = 1'b1;
                blk_sel      = BIW'(r_idx);
                if (r_idx < cnt) begin
                    tbl_ctl.tbl_rd = 1'b1;
                    n_idx          = CW'(r_idx + 1'b1);
                end else begin
                    n_state = S_FREE_DONE;
                end
            end

            S_FREE_DONE: begin
                if (out_free) begin
                    emit           = 1'b1;
                    tbl_ctl.cnt_wr = 1'b1;
                    cnt_wdata      = '0;
                    n_state        = S_IDLE;
                end
            end

            // report entry idx-1, fetch entry idx
            S_QUERY: begin
                blk_sel = BIW'(r_idx);
                if (out_free) begin
                    emit   = 1'b1;
                    e_phys = PHYS_W'(tbl_phys);
                    e_lpos = LPOS_W'(r_idx - 1'b1);
                    e_bst  = tbl_state;
                    e_last = (r_idx == query_n);
                    if (r_idx < query_n) begin
                        tbl_ctl.tbl_rd = 1'b1;
                        n_idx          = CW'(r_idx + 1'b1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // response buffer valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // response buffer word
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= e_status;
            r_out_phys   <= e_phys;
            r_out_lpos   <= e_lpos;
            r_out_bst    <= e_bst;
            r_out_last   <= e_last;
        end
    end

    assign i_req.ready            = req_ready;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.physical_index   = r_out_phys;
    assign o_rsp.logical_position = r_out_lpos;
    assign o_rsp.block_state      = r_out_bst;
    assign o_rsp.last             = r_out_last;

    `PBA_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, accept, r_state == S_DECODE)
    `PBA_ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n, emit && e_last, r_state == S_IDLE)

endmodule

[tb/paged_block_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged block allocator testbench
// Sends allocate, free, state update and query words to the allocator, with
// random gaps on the request side and random stalls on the response side.
// Every response word is checked against a model of the free stack and the
// per-sequence block tables kept inside the bench.
// ----------------------------------------------------------------------------
module paged_block_allocator_test;
    import pba_pkg::*;

    localparam int NUM_BLOCKS         = 1024;
    localparam int MAX_SEQS           = 64;
    localparam int MAX_BLOCKS_PER_SEQ = 64;
    localparam int CYCLE_LIMIT        = 500_000;
    localparam int DRAIN_CYCLES       = 80;
    localparam int SHOW_LIMIT         = 10;

    // one response word as seen on o_rsp
    typedef struct packed {
        t_status           status;
        logic [PHYS_W-1:0] phys;
        logic [LPOS_W-1:0] lpos;
        t_blk_state        bstate;
        logic              last;
    } t_rsp_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pba_req_if req_if ();
    pba_rsp_if rsp_if ();

    paged_block_allocator #(
        .NUM_BLOCKS         (NUM_BLOCKS),
        .MAX_SEQS           (MAX_SEQS),
        .MAX_BLOCKS_PER_SEQ (MAX_BLOCKS_PER_SEQ)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    // bench copy of the pool and block tables
    logic [PHYS_W-1:0] pool_stack [NUM_BLOCKS];
    logic [10:0]       pool_depth;
    logic [PHYS_W-1:0] tbl_phys   [MAX_SEQS][MAX_BLOCKS_PER_SEQ];
    t_blk_state        tbl_state  [MAX_SEQS][MAX_BLOCKS_PER_SEQ];
    logic [6:0]        seq_len    [MAX_SEQS];

    t_rsp_word pending_rsp [$];

    bit src_idle_en;
    bit sink_idle_en;
    int sink_hold;
    int cycle_cnt;
    int err_count;
    int shown_count;
    int word_count;
    int req_count;
    int op_hits [4];

    function automatic void pool_reset();
        for (int k = 0; k < NUM_BLOCKS; k++) begin
            pool_stack[k] = PHYS_W'(NUM_BLOCKS - 1 - k);
        end
        pool_depth = 11'(NUM_BLOCKS);
        foreach (seq_len[s]) seq_len[s] = '0;
    endfunction

    function automatic void expect_word(t_status st, logic [PHYS_W-1:0] phys,
                                        logic [LPOS_W-1:0] lpos, t_blk_state bs,
                                        logic last);
        t_rsp_word w;
        w.status = st;
        w.phys   = phys;
        w.lpos   = lpos;
        w.bstate = bs;
        w.last   = last;
        pending_rsp.insert(pending_rsp.size(), w);
    endfunction

    // apply one accepted request to the pool and queue its response words
    function automatic void pool_apply(t_op op, logic [SEQ_W-1:0] seq,
                                       logic [LIDX_W-1:0] li, t_blk_state ns);
        logic [6:0] cnt;
        int         n;
        cnt = seq_len[seq];
        if (op != OP_ALLOC && cnt == 0) begin
            expect_word(ST_NOT_FOUND, '0, '0, BS_HOT, 1'b1);
            return;
        end
        case (op)
            OP_ALLOC: begin
                if (pool_depth == 0) begin
                    expect_word(ST_NO_FREE, '0, '0, BS_HOT, 1'b1);
                end else if (cnt >= MAX_BLOCKS_PER_SEQ) begin
                    expect_word(ST_FULL, '0, '0, BS_HOT, 1'b1);
                end else begin
                    pool_depth          = pool_depth - 1'b1;
                    tbl_phys[seq][cnt]  = pool_stack[pool_depth];
                    tbl_state[seq][cnt] = BS_HOT;
                    seq_len[seq]        = cnt + 1'b1;
                    expect_word(ST_OK, pool_stack[pool_depth], cnt[5:0], BS_HOT, 1'b1);
                end
            end
            OP_FREE: begin
                // blocks go back in table order, so the last one ends on top
                for (int i = 0; i < cnt; i++) begin
                    if (pool_depth < NUM_BLOCKS) begin
                        pool_stack[pool_depth] = tbl_phys[seq][i];
                        pool_depth             = pool_depth + 1'b1;
                    end
                end
                seq_len[seq] = '0;
                expect_word(ST_OK, '0, '0, BS_HOT, 1'b1);
            end
            OP_UPDATE: begin
                if (li >= cnt) begin
                    expect_word(ST_RANGE, '0, '0, BS_HOT, 1'b1);
                end else if (ns == BS_INVALID) begin
                    expect_word(ST_BAD_STATE, '0, '0, BS_HOT, 1'b1);
                end else begin
                    tbl_state[seq][li] = ns;
                    expect_word(ST_OK, tbl_phys[seq][li], li, ns, 1'b1);
                end
            end
            default: begin
                n = (cnt > RESULT_CAP) ? RESULT_CAP : cnt;
                for (int i = 0; i < n; i++) begin
                    expect_word(ST_OK, tbl_phys[seq][i], LPOS_W'(i), tbl_state[seq][i],
                                i == n - 1);
                end
            end
        endcase
    endfunction

    // drive one request word, optionally after an idle burst
    task automatic send_req(t_op op, logic [SEQ_W-1:0] seq, logic [LIDX_W-1:0] li,
                            t_blk_state ns);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid         <= 1'b1;
        req_if.operation     <= op;
        req_if.seq_id        <= seq;
        req_if.logical_index <= li;
        req_if.target_state  <= ns;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pool_apply(op, seq, li, ns);
        req_count++;
        op_hits[op]++;
    endtask

    task automatic send_rand(t_op op, logic [SEQ_W-1:0] seq);
        send_req(op, seq, LIDX_W'($urandom_range(0, 63)), t_blk_state'($urandom_range(0, 3)));
    endtask

    // sink side: random stall bursts on ready
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold    <= sink_hold - 1;
            rsp_if.ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
            sink_hold    <= $urandom_range(0, 6);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // response check against the oldest queued word
    always @(posedge i_clk) begin : rsp_check
        t_rsp_word got;
        t_rsp_word want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.status = t_status'(rsp_if.status);
            got.phys   = rsp_if.physical_index;
            got.lpos   = rsp_if.logical_position;
            got.bstate = t_blk_state'(rsp_if.block_state);
            got.last   = rsp_if.last;
            word_count++;
            if (pending_rsp.size() == 0) begin
                err_count++;
                if (shown_count < SHOW_LIMIT) begin
                    shown_count++;
                    $display("%0t: unexpected word status %0d phys %0d pos %0d state %0d last %0d",
                             $realtime, got.status, got.phys, got.lpos, got.bstate, got.last);
                end
            end else begin
                want = pending_rsp.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (shown_count < SHOW_LIMIT) begin
                        shown_count++;
                        $display("%0t: word mismatch exp st %0d ph %0d pos %0d bs %0d last %0d",
                                 $realtime, want.status, want.phys, want.lpos, want.bstate,
                                 want.last);
                        $display("%0t:                got st %0d ph %0d pos %0d bs %0d last %0d",
                                 $realtime, got.status, got.phys, got.lpos, got.bstate,
                                 got.last);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, pending_rsp.size());
            $display("paged_block_allocator_test failed");
            $finish;
        end
    end

    // fresh pool: not found paths, first handouts, update checks, LIFO reuse
    task automatic test_fresh_pool();
        send_req(OP_QUERY,  6'd0,  6'd0, BS_HOT);
        send_req(OP_FREE,   6'd5,  6'd0, BS_HOT);
        send_req(OP_UPDATE, 6'd63, 6'd0, BS_WARM);
        send_req(OP_ALLOC,  6'd0,  6'd63, BS_INVALID);
        send_req(OP_ALLOC,  6'd0,  6'd0, BS_HOT);
        send_req(OP_ALLOC,  6'd63, 6'd0, BS_COLD);
        send_req(OP_UPDATE, 6'd0,  6'd1, BS_WARM);
        send_req(OP_UPDATE, 6'd0,  6'd0, BS_COLD);
        send_req(OP_UPDATE, 6'd0,  6'd2, BS_WARM);
        send_req(OP_UPDATE, 6'd0,  6'd63, BS_INVALID);
        send_req(OP_UPDATE, 6'd0,  6'd0, BS_INVALID);
        send_req(OP_UPDATE, 6'd0,  6'd1, BS_HOT);
        send_req(OP_QUERY,  6'd0,  6'd0, BS_HOT);
        send_req(OP_QUERY,  6'd63, 6'd63, BS_INVALID);
        send_req(OP_FREE,   6'd0,  6'd0, BS_HOT);
        send_req(OP_ALLOC,  6'd21, 6'd0, BS_HOT);
        send_req(OP_ALLOC,  6'd21, 6'd0, BS_HOT);
        send_req(OP_QUERY,  6'd21, 6'd0, BS_HOT);
        send_req(OP_FREE,   6'd21, 6'd0, BS_HOT);
        send_req(OP_FREE,   6'd63, 6'd0, BS_HOT);
        send_req(OP_FREE,   6'd21, 6'd0, BS_HOT);
    endtask

    // one sequence filled to its table limit, updated and queried, then one more allocate and a free
    task automatic test_table_full();
        for (int b = 0; b < MAX_BLOCKS_PER_SEQ; b++) send_rand(OP_ALLOC, 6'd42);
        send_req(OP_UPDATE, 6'd42, 6'd63, BS_COLD);
        send_req(OP_UPDATE, 6'd42, 6'd0, BS_WARM);
        send_req(OP_QUERY,  6'd42, 6'd0, BS_HOT);
        send_req(OP_ALLOC,  6'd42, 6'd0, BS_HOT);
        send_req(OP_FREE,   6'd42, 6'd0, BS_HOT);
    endtask

    // random mix focused on a handful of live sequences
    task automatic test_random_mix(int n_req);
        logic [SEQ_W-1:0]  live_seq [8];
        logic [SEQ_W-1:0]  seq;
        logic [LIDX_W-1:0] li;
        t_op               op;
        t_blk_state        ns;
        int                pick;
        foreach (live_seq[k]) live_seq[k] = SEQ_W'($urandom_range(0, 63));
        for (int k = 0; k < n_req; k++) begin
            // quiet tail: no gaps, no stalls
            if (k == n_req * 2 / 3) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) seq = SEQ_W'($urandom_range(0, 63));
            else seq = live_seq[$urandom_range(0, 7)];
            pick = $urandom_range(0, 99);
            op = (pick < 40) ? OP_ALLOC : (pick < 70) ? OP_UPDATE :
                 (pick < 88) ? OP_QUERY : OP_FREE;
            if (seq_len[seq] != 0 && $urandom_range(0, 4) != 0) begin
                li = LIDX_W'($urandom_range(0, seq_len[seq] - 1));
            end else begin
                li = LIDX_W'($urandom_range(0, 63));
            end
            if ($urandom_range(0, 9) == 0) ns = BS_INVALID;
            else ns = t_blk_state'($urandom_range(0, 2));
            send_req(op, seq, li, ns);
        end
    endtask

    initial begin
        req_if.valid         = 1'b0;
        req_if.operation     = OP_ALLOC;
        req_if.seq_id        = '0;
        req_if.logical_index = '0;
        req_if.target_state  = BS_HOT;
        pool_reset();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fresh_pool();
        test_table_full();
        test_random_mix(90);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests: %0d allocate, %0d free, %0d update, %0d query",
                 req_count, op_hits[OP_ALLOC], op_hits[OP_FREE], op_hits[OP_UPDATE],
                 op_hits[OP_QUERY]);
        $display("checked %0d response words, %0d errors, one table filled to its limit",
                 word_count, err_count);
        if (err_count == 0) begin
            $display("paged_block_allocator_test passed");
        end else begin
            $display("paged_block_allocator_test failed");
        end
        $finish;
    end

endmodule
